/* rtl/rbs_pkg.sv */
// rbs_pkg: transaction structs, opcodes and controller states of the
// rank bucket scheduler; no dependencies
package rbs_pkg;

    localparam int PEND_WORD_W = 64;
    localparam int PEND_POS_W  = 6;

    typedef enum logic [1:0] {
        OP_SCHEDULE = 2'd0,
        OP_START    = 2'd1,
        OP_POP      = 2'd2,
        OP_NOP      = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode    opcode;
        logic [9:0] node_id;
        logic [5:0] node_rank;
    } t_cmd;

    typedef struct packed {
        logic [9:0] out_node;
        logic [5:0] out_rank;
        logic       node_valid;
        logic       cycle_done;
        logic       duplicate;
    } t_result;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCHED_RD,
        ST_SCHED_LINK,
        ST_POP_REL,
        ST_SCAN,
        ST_POP_HEAD
    } t_state;

endpackage

/* rtl/rbs_ram.sv */
// rbs_ram: generic simple dual-port ram, one write port, one read port
// with registered read data; no dependencies
module rbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/rank_bucket_scheduler.sv */
// rank_bucket_scheduler: top level, rank-ordered node scheduler with per-rank
// fifo lists threaded through a link ram; uses rbs_pkg and rbs_ram
//
// usage: a command transaction (schedule, start cycle, pop) is taken when
// start is high and busy is low. every command gives exactly one result on
// o_result, marked by o_strobe for one cycle; the receiver cannot stall it.
// busy drops in the same cycle the strobe rises, so the next command may
// follow at once.
// steps per command (accept to strobe):
//   start cycle, no-op, ignored schedule: answered straight from idle
//   schedule: read step; link step too unless duplicate or rank list empty
//     (link ram has one write port: node entry, then old tail entry)
//   pop continuing a list: link ram read, then release write
//   pop taking a new rank or ending in cycle_done: release of any running
//     node, a search step per 64-rank group searched, head taken if found
// list state sits in two rams: link (NUM_NODES x node width + 2) and
// rank heads/tails (NUM_RANKS x 2 node widths).
// reset: a clearing pass empties all NUM_NODES link ram entries; busy
// stays high until it ends. pending bits, cursor and running node clear
// at once.
module rank_bucket_scheduler #(
    parameter int NUM_NODES = 1024,
    parameter int NUM_RANKS = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  rbs_pkg::t_cmd   i_cmd,
    output logic            busy,
    output logic            o_strobe,
    output rbs_pkg::t_result o_result
);
    import rbs_pkg::*;

    localparam int NODE_W = $clog2(NUM_NODES);
    localparam int RANK_W = $clog2(NUM_RANKS);
    localparam int CUR_W  = $clog2(NUM_RANKS + 1);
    localparam int LINK_W = NODE_W + 2;
    localparam int HT_W   = 2 * NODE_W;
    localparam int GROUPS = (NUM_RANKS + PEND_WORD_W - 1) / PEND_WORD_W;
    localparam int GIDX_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int GRP_W  = GIDX_W + 1;
    localparam int PEND_W = GROUPS * PEND_WORD_W;
    localparam int PIDX_W = $clog2(PEND_W);
    localparam int L_Q    = NODE_W + 1;
    localparam int L_NX   = NODE_W;

    t_state r_state, n_state;
    logic [NODE_W-1:0] r_clr, n_clr;
    logic [NODE_W-1:0] r_id, n_id;
    logic [RANK_W-1:0] r_rank, n_rank;
    logic [NODE_W-1:0] r_tail, n_tail;
    logic [NODE_W-1:0] r_run, n_run;
    logic r_run_vld, n_run_vld;
    logic [RANK_W-1:0] r_crank, n_crank;
    logic [CUR_W-1:0] r_cursor, n_cursor;
    logic [GRP_W-1:0] r_grp, n_grp;
    logic [PEND_W-1:0] r_pend, n_pend;
    logic r_strobe, n_strobe;
    t_result r_result, n_result;

    logic link_we;
    logic [NODE_W-1:0] link_waddr, link_raddr;
    logic [LINK_W-1:0] link_wdata, link_q;
    logic rank_we;
    logic [RANK_W-1:0] rank_waddr, rank_raddr;
    logic [HT_W-1:0] rank_wdata, rank_q;

    logic in_ok;
    logic pend_hit;
    logic grp_ok;
    logic [PEND_WORD_W-1:0] word;
    logic [PEND_WORD_W-1:0] cand;
    logic scan_found;
    logic [PEND_POS_W-1:0] scan_pos;
    logic [RANK_W-1:0] scan_rank;
    logic [PIDX_W-1:0] scan_pidx;
    logic [GRP_W-1:0] cur_grp;

    rbs_ram #(.WIDTH(LINK_W), .DEPTH(NUM_NODES)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (link_raddr),
        .o_rdata (link_q)
    );

    rbs_ram #(.WIDTH(HT_W), .DEPTH(NUM_RANKS)) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (rank_we),
        .i_waddr (rank_waddr),
        .i_wdata (rank_wdata),
        .i_raddr (rank_raddr),
        .o_rdata (rank_q)
    );

    assign in_ok = (32'(i_cmd.node_id) < 32'(NUM_NODES))
                && (32'(i_cmd.node_rank) < 32'(NUM_RANKS));
    assign pend_hit = r_pend[PIDX_W'(r_rank)];
    assign grp_ok = (r_grp < GRP_W'(GROUPS));
    assign cur_grp = GRP_W'(r_cursor >> PEND_POS_W);

    // pending-bit search over one 64-rank group
    always_comb begin
        word = '0;
        if (grp_ok) begin
            word = r_pend[PEND_WORD_W * int'(r_grp[GIDX_W-1:0]) +: PEND_WORD_W];
        end
        for (int b = 0; b < PEND_WORD_W; b++) begin
            cand[b] = word[b]
                   && ((int'(r_grp) * PEND_WORD_W + b) >= int'(r_cursor));
        end
        scan_found = 1'b0;
        scan_pos = '0;
        for (int b = PEND_WORD_W - 1; b >= 0; b--) begin
            if (cand[b]) begin
                scan_found = 1'b1;
                scan_pos = PEND_POS_W'(b);
            end
        end
        scan_rank = RANK_W'(int'(r_grp) * PEND_WORD_W + int'(scan_pos));
        scan_pidx = PIDX_W'(int'(r_grp) * PEND_WORD_W + int'(scan_pos));
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == NODE_W'(NUM_NODES - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (start) begin
                    case (i_cmd.opcode)
                        OP_SCHEDULE: if (in_ok) n_state = ST_SCHED_RD;
                        OP_POP:      n_state = r_run_vld ? ST_POP_REL : ST_SCAN;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SCHED_RD: begin
                if (!link_q[L_Q] && pend_hit) n_state = ST_SCHED_LINK;
                else n_state = ST_IDLE;
            end
            ST_SCHED_LINK: n_state = ST_IDLE;
            ST_POP_REL: n_state = link_q[L_NX] ? ST_IDLE : ST_SCAN;
            ST_SCAN: begin
                if (!grp_ok) n_state = ST_IDLE;
                else if (scan_found) n_state = ST_POP_HEAD;
            end
            ST_POP_HEAD: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and ram controls
    always_comb begin
        n_clr     = r_clr;
        n_id      = r_id;
        n_rank    = r_rank;
        n_tail    = r_tail;
        n_run     = r_run;
        n_run_vld = r_run_vld;
        n_crank   = r_crank;
        n_cursor  = r_cursor;
        n_grp     = r_grp;
        n_pend    = r_pend;
        n_strobe  = 1'b0;
        n_result  = '0;
        link_we    = 1'b0;
        link_waddr = r_id;
        link_wdata = '0;
        link_raddr = r_run;
        rank_we    = 1'b0;
        rank_waddr = r_rank;
        rank_wdata = {r_id, r_id};
        rank_raddr = scan_rank;
        case (r_state)
            ST_CLEAR: begin
                link_we    = 1'b1;
                link_waddr = r_clr;
                n_clr      = r_clr + NODE_W'(1);
            end
            ST_IDLE: begin
                n_id   = NODE_W'(i_cmd.node_id);
                n_rank = RANK_W'(i_cmd.node_rank);
                link_raddr = NODE_W'(i_cmd.node_id);
                rank_raddr = RANK_W'(i_cmd.node_rank);
                n_grp = cur_grp;
                if (start) begin
                    case (i_cmd.opcode)
                        OP_SCHEDULE: n_strobe = !in_ok;
                        OP_START: begin
                            n_cursor = '0;
                            n_strobe = 1'b1;
                        end
                        OP_POP: link_raddr = r_run;
                        default: n_strobe = 1'b1;
                    endcase
                end
            end
            ST_SCHED_RD: begin
                if (link_q[L_Q]) begin
                    n_strobe = 1'b1;
                    n_result.duplicate = 1'b1;
                end else begin
                    link_we    = 1'b1;
                    link_waddr = r_id;
                    link_wdata = {1'b1, 1'b0, NODE_W'(0)};
                    rank_we    = 1'b1;
                    rank_wdata = {pend_hit ? rank_q[HT_W-1:NODE_W] : r_id, r_id};
                    n_pend[PIDX_W'(r_rank)] = 1'b1;
                    n_tail = rank_q[NODE_W-1:0];
                    n_strobe = !pend_hit;
                end
            end
            ST_SCHED_LINK: begin
                link_we    = 1'b1;
                link_waddr = r_tail;
                link_wdata = {1'b1, 1'b1, r_id};
                n_strobe   = 1'b1;
            end
            ST_POP_REL: begin
                link_we    = 1'b1;
                link_waddr = r_run;
                link_wdata = '0;
                n_run_vld  = 1'b0;
                n_grp      = cur_grp;
                if (link_q[L_NX]) begin
                    n_run     = link_q[NODE_W-1:0];
                    n_run_vld = 1'b1;
                    n_strobe  = 1'b1;
                    n_result.out_node   = 10'(link_q[NODE_W-1:0]);
                    n_result.out_rank   = 6'(r_crank);
                    n_result.node_valid = 1'b1;
                end
            end
            ST_SCAN: begin
                if (!grp_ok) begin
                    n_strobe = 1'b1;
                    n_result.cycle_done = 1'b1;
                end else if (scan_found) begin
                    n_pend[scan_pidx] = 1'b0;
                    n_cursor = CUR_W'(int'(scan_rank) + 1);
                    n_crank  = scan_rank;
                end else begin
                    n_grp = r_grp + GRP_W'(1);
                end
            end
            ST_POP_HEAD: begin
                n_run     = rank_q[HT_W-1:NODE_W];
                n_run_vld = 1'b1;
                n_strobe  = 1'b1;
                n_result.out_node   = 10'(rank_q[HT_W-1:NODE_W]);
                n_result.out_rank   = 6'(r_crank);
                n_result.node_valid = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_run_vld <= 1'b0;
            r_cursor  <= '0;
            r_pend    <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_run_vld <= n_run_vld;
            r_cursor  <= n_cursor;
            r_pend    <= n_pend;
            r_strobe  <= n_strobe;
        end
        r_id     <= n_id;
        r_rank   <= n_rank;
        r_tail   <= n_tail;
        r_run    <= n_run;
        r_crank  <= n_crank;
        r_grp    <= n_grp;
        r_result <= n_result;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
